// ===== design/irq_nmi_latch_mask_controller_macros.svh =====
// ----------------------------------------------------------------------------
// irq_nmi_latch_mask_controller assertion macros
// Shorthand for the clocked, reset-qualified checks of the controller.
// ----------------------------------------------------------------------------
`ifndef IRQ_NMI_LATCH_MASK_CONTROLLER_MACROS_SVH
`define IRQ_NMI_LATCH_MASK_CONTROLLER_MACROS_SVH

// same-cycle implication
`define INMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define INMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/inmc_pkg.sv =====
// ----------------------------------------------------------------------------
// inmc_pkg
// Command codes, bit positions and transfer types of the interrupt controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package inmc_pkg;

	typedef enum logic [3:0] {
		CMD_CAS_RISE     = 4'd0,
		CMD_CAS_FALL     = 4'd1,
		CMD_CAS_CLEAR    = 4'd2,
		CMD_TIMER        = 4'd3,
		CMD_DISK         = 4'd4,
		CMD_MOTOR_OFF    = 4'd5,
		CMD_UART_ERR     = 4'd6,
		CMD_UART_RCV     = 4'd7,
		CMD_UART_SND     = 4'd8,
		CMD_RESET_BUTTON = 4'd9,
		CMD_IRQ_READ     = 4'd10,
		CMD_IRQ_MASK_WR  = 4'd11,
		CMD_NMI_READ     = 4'd12,
		CMD_NMI_MASK_WR  = 4'd13,
		CMD_NMI_TAKEN    = 4'd14
	} cmd_t;

	localparam logic [2:0] MODEL_EARLY = 3'd1;

	localparam logic [7:0] EARLY_TIMER   = 8'h80;
	localparam logic [7:0] EARLY_DISK    = 8'h40;
	localparam logic [7:0] LATE_UART_ERR = 8'h40;
	localparam logic [7:0] LATE_UART_RCV = 8'h20;
	localparam logic [7:0] LATE_UART_SND = 8'h10;
	localparam logic [7:0] LATE_TIMER    = 8'h04;
	localparam logic [7:0] LATE_CAS_FALL = 8'h02;
	localparam logic [7:0] LATE_CAS_RISE = 8'h01;
	localparam logic [7:0] NMI_INTRQ     = 8'h80;
	localparam logic [7:0] NMI_MOTOROFF  = 8'h40;
	localparam logic [7:0] NMI_RESET     = 8'h20;
	localparam logic [7:0] NMI_CONSTANT  = 8'h01;

	typedef struct packed {
		logic [3:0] command;
		logic       level;
		logic [7:0] write_data;
	} item_t;

	typedef struct packed {
		logic [1:0] cassette_enables;
		logic       nmi_seen_out;
		logic       nmi_out;
		logic       irq_out;
		logic [7:0] read_data;
	} result_t;

endpackage

// ===== design/inmc_core.sv =====
// ----------------------------------------------------------------------------
// inmc_core
// Latch, mask and line registers with the combinational command update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module inmc_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_data,
	input  logic                  step,
	input  inmc_pkg::item_t       item,
	output inmc_pkg::result_t     result
);

	logic [2:0] model_q;
	logic [7:0] irq_latch_q, irq_mask_q, nmi_latch_q, nmi_mask_q;
	logic       irq_line_q, nmi_line_q, nmi_seen_q;

	logic [7:0] il, im, nl, nm, rd, b;
	logic       irq, nmi, seen, early;

	always_comb begin
		il    = irq_latch_q;
		im    = irq_mask_q;
		nl    = nmi_latch_q;
		nm    = nmi_mask_q;
		irq   = irq_line_q;
		nmi   = nmi_line_q;
		seen  = nmi_seen_q;
		rd    = 8'h00;
		b     = 8'h00;
		early = (model_q == inmc_pkg::MODEL_EARLY);
		unique case (item.command) inside
			inmc_pkg::CMD_CAS_RISE, inmc_pkg::CMD_CAS_FALL: begin
				b   = (item.command == inmc_pkg::CMD_CAS_RISE) ?
				      inmc_pkg::LATE_CAS_RISE : inmc_pkg::LATE_CAS_FALL;
				il  = (il & ~b) | (im & b);
				irq = |(il & im);
			end
			inmc_pkg::CMD_CAS_CLEAR: begin
				il  = il & ~(inmc_pkg::LATE_CAS_RISE | inmc_pkg::LATE_CAS_FALL);
				irq = |(il & im);
			end
			inmc_pkg::CMD_TIMER, inmc_pkg::CMD_DISK: begin
				if (early) begin
					b  = (item.command == inmc_pkg::CMD_TIMER) ?
					     inmc_pkg::EARLY_TIMER : inmc_pkg::EARLY_DISK;
					il = item.level ? (il | b) : (il & ~b);
					if (item.level) begin
						irq = 1'b1;
					end
				end else if (item.command == inmc_pkg::CMD_TIMER) begin
					b   = inmc_pkg::LATE_TIMER;
					il  = item.level ? (il | b) : (il & ~b);
					irq = |(il & im);
				end else begin
					b   = inmc_pkg::NMI_INTRQ;
					nl  = item.level ? (nl | b) : (nl & ~b);
					nmi = |(nl & nm);
					if (!nmi) begin
						seen = 1'b0;
					end
				end
			end
			inmc_pkg::CMD_MOTOR_OFF: begin
				if (!early) begin
					b   = inmc_pkg::NMI_MOTOROFF;
					nl  = item.level ? (nl | b) : (nl & ~b);
					nmi = |(nl & nm);
					if (!nmi) begin
						seen = 1'b0;
					end
				end
			end
			inmc_pkg::CMD_UART_ERR, inmc_pkg::CMD_UART_RCV, inmc_pkg::CMD_UART_SND: begin
				if (!early) begin
					b   = (item.command == inmc_pkg::CMD_UART_ERR) ? inmc_pkg::LATE_UART_ERR :
					      (item.command == inmc_pkg::CMD_UART_RCV) ? inmc_pkg::LATE_UART_RCV :
					      inmc_pkg::LATE_UART_SND;
					il  = item.level ? (il | b) : (il & ~b);
					irq = |(il & im);
				end
			end
			inmc_pkg::CMD_RESET_BUTTON: begin
				if (early) begin
					nmi = item.level;
				end else begin
					b   = inmc_pkg::NMI_RESET;
					nl  = item.level ? (nl | b) : (nl & ~b);
					nmi = |(nl & nm);
				end
				if (!nmi) begin
					seen = 1'b0;
				end
			end
			inmc_pkg::CMD_IRQ_READ: begin
				if (early) begin
					rd  = il;
					il  = il & ~inmc_pkg::EARLY_TIMER;
					irq = |il;
				end else begin
					rd = ~il;
				end
			end
			inmc_pkg::CMD_IRQ_MASK_WR: begin
				im  = item.write_data;
				irq = |(il & im);
			end
			inmc_pkg::CMD_NMI_READ: begin
				rd = ~nl;
			end
			inmc_pkg::CMD_NMI_MASK_WR: begin
				nm  = (item.write_data & (inmc_pkg::NMI_INTRQ | inmc_pkg::NMI_MOTOROFF)) |
				      inmc_pkg::NMI_RESET;
				nmi = |(nl & nm);
				if (!nmi) begin
					seen = 1'b0;
				end
			end
			inmc_pkg::CMD_NMI_TAKEN: begin
				if (nmi) begin
					seen = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= inmc_pkg::MODEL_EARLY;
		end else if (cfg_we) begin
			model_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_latch_q <= 8'h00;
			irq_mask_q  <= 8'h00;
			nmi_latch_q <= inmc_pkg::NMI_CONSTANT;
			nmi_mask_q  <= inmc_pkg::NMI_RESET;
			irq_line_q  <= 1'b0;
			nmi_line_q  <= 1'b0;
			nmi_seen_q  <= 1'b0;
		end else if (step) begin
			irq_latch_q <= il;
			irq_mask_q  <= im;
			nmi_latch_q <= nl;
			nmi_mask_q  <= nm;
			irq_line_q  <= irq;
			nmi_line_q  <= nmi;
			nmi_seen_q  <= seen;
		end
	end

	assign result.read_data        = rd;
	assign result.irq_out          = irq;
	assign result.nmi_out          = nmi;
	assign result.nmi_seen_out     = seen;
	assign result.cassette_enables = im[1:0];

endmodule

// ===== design/irq_nmi_latch_mask_controller.sv =====
// ----------------------------------------------------------------------------
// irq_nmi_latch_mask_controller
// IRQ/NMI latch and mask controller of an 8-bit home computer. Each transfer
// on the s_ side is one command (source event, status read, mask write or NMI
// taken) and yields exactly one status transfer on the m_ side. One command
// is taken every cycle while the m_ side accepts results; an input register
// is followed by a result register, and the command update loops through
// the latch and mask registers. A waiting result lets a command into an empty
// input register but holds one already there. The machine model register
// is written on the cfg_ port and must only change while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irq_nmi_latch_mask_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data,    // machine_model
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // level [0], write_data [8:1], zero [15:9]
	input  logic [3:0]  s_tuser,     // command [3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata      // read_data [7:0], irq_out [8], nmi_out [9],
	                                 // nmi_seen_out [10], cassette_enables [12:11],
	                                 // zero [15:13]
);

	logic              valid_s1;
	inmc_pkg::item_t   item_s1;
	logic              advance;
	inmc_pkg::result_t result;
	inmc_pkg::result_t result_q;
	logic              out_valid_q;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command    <= s_tuser;
			item_s1.level      <= s_tdata[0];
			item_s1.write_data <= s_tdata[8:1];
		end
	end

	inmc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.step     (advance),
		.item     (item_s1),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, result_q};

endmodule

// ===== design/inmc_checker.sv =====
// ----------------------------------------------------------------------------
// inmc_checker
// Port-level checks of the interrupt controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "irq_nmi_latch_mask_controller_macros.svh"

module inmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	`INMC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`INMC_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
	`INMC_ASSERT_IMP(a_in_flow, clk, arst_n, m_tready, s_tready, "input stalled with output side ready")
	`INMC_ASSERT_IMP(a_seen_line, clk, arst_n, m_tvalid && m_tdata[10], m_tdata[9], "nmi seen without nmi line")

endmodule

bind irq_nmi_latch_mask_controller inmc_checker u_inmc_checker (.*);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IRQ/NMI latch and mask controller. Two directed
// runs walk commands through the early and then the later bit layout. Random
// command streams then follow under a range of machine models, with the
// sender gapping and the receiver stalling at varied rates. A predictor
// mirrors the latch, mask and line state, and each status transfer is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam logic [3:0] CMD_UNUSED = 4'd15;
	localparam int N_PHASES = 10;
	localparam int PHASE_ITEMS = 150;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;     // level [0], write_data [8:1], zero [15:9]
	logic [3:0]  s_tuser;     // command [3:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;     // read_data [7:0], irq_out [8], nmi_out [9],
	                          // nmi_seen_out [10], cassette_enables [12:11]

	irq_nmi_latch_mask_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	inmc_pkg::item_t   cmd_backlog [$];
	inmc_pkg::result_t status_due [$];

	logic [2:0] model_q;
	logic [7:0] irq_latch_q, irq_mask_q, nmi_latch_q, nmi_mask_q;
	logic       irq_line_q, nmi_line_q, nmi_seen_q;

	int  send_gap_pct;
	int  rx_stall_pct;
	logic s_fire;
	int  errors;
	int  cmds_accepted;
	int  status_checked;
	int  models_used;

	int phase_model [N_PHASES] = '{1, 4, 2, 7, 1, 3, 0, 5, 6, 4};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [7:0] with_bit(logic [7:0] v, logic [7:0] b, logic on);
		return on ? (v | b) : (v & ~b);
	endfunction

	function automatic void refresh_irq();
		irq_line_q = |(irq_latch_q & irq_mask_q);
	endfunction

	function automatic void refresh_nmi();
		nmi_line_q = |(nmi_latch_q & nmi_mask_q);
		if (!nmi_line_q)
			nmi_seen_q = 1'b0;
	endfunction

	function automatic inmc_pkg::result_t predict_status(inmc_pkg::item_t it);
		inmc_pkg::result_t r;
		logic              early;
		logic [7:0]        b;
		early = (model_q == inmc_pkg::MODEL_EARLY);
		r = '0;
		case (it.command) inside
		inmc_pkg::CMD_CAS_RISE, inmc_pkg::CMD_CAS_FALL: begin
			b = (it.command == inmc_pkg::CMD_CAS_RISE) ?
			    inmc_pkg::LATE_CAS_RISE : inmc_pkg::LATE_CAS_FALL;
			irq_latch_q = (irq_latch_q & ~b) | (irq_mask_q & b);
			refresh_irq();
		end
		inmc_pkg::CMD_CAS_CLEAR: begin
			irq_latch_q = irq_latch_q &
			              ~(inmc_pkg::LATE_CAS_RISE | inmc_pkg::LATE_CAS_FALL);
			refresh_irq();
		end
		inmc_pkg::CMD_TIMER, inmc_pkg::CMD_DISK: begin
			if (early) begin
				b = (it.command == inmc_pkg::CMD_TIMER) ?
				    inmc_pkg::EARLY_TIMER : inmc_pkg::EARLY_DISK;
				irq_latch_q = with_bit(irq_latch_q, b, it.level);
				if (it.level)
					irq_line_q = 1'b1;
			end else if (it.command == inmc_pkg::CMD_TIMER) begin
				irq_latch_q = with_bit(irq_latch_q, inmc_pkg::LATE_TIMER, it.level);
				refresh_irq();
			end else begin
				nmi_latch_q = with_bit(nmi_latch_q, inmc_pkg::NMI_INTRQ, it.level);
				refresh_nmi();
			end
		end
		inmc_pkg::CMD_MOTOR_OFF: begin
			if (!early) begin
				nmi_latch_q = with_bit(nmi_latch_q, inmc_pkg::NMI_MOTOROFF, it.level);
				refresh_nmi();
			end
		end
		inmc_pkg::CMD_UART_ERR, inmc_pkg::CMD_UART_RCV, inmc_pkg::CMD_UART_SND: begin
			if (!early) begin
				b = (it.command == inmc_pkg::CMD_UART_ERR) ? inmc_pkg::LATE_UART_ERR :
				    (it.command == inmc_pkg::CMD_UART_RCV) ? inmc_pkg::LATE_UART_RCV :
				    inmc_pkg::LATE_UART_SND;
				irq_latch_q = with_bit(irq_latch_q, b, it.level);
				refresh_irq();
			end
		end
		inmc_pkg::CMD_RESET_BUTTON: begin
			if (early) begin
				nmi_line_q = it.level;
				if (!nmi_line_q)
					nmi_seen_q = 1'b0;
			end else begin
				nmi_latch_q = with_bit(nmi_latch_q, inmc_pkg::NMI_RESET, it.level);
				refresh_nmi();
			end
		end
		inmc_pkg::CMD_IRQ_READ: begin
			if (early) begin
				r.read_data = irq_latch_q;
				irq_latch_q = irq_latch_q & ~inmc_pkg::EARLY_TIMER;
				irq_line_q = |irq_latch_q;
			end else begin
				r.read_data = ~irq_latch_q;
			end
		end
		inmc_pkg::CMD_IRQ_MASK_WR: begin
			irq_mask_q = it.write_data;
			refresh_irq();
		end
		inmc_pkg::CMD_NMI_READ: r.read_data = ~nmi_latch_q;
		inmc_pkg::CMD_NMI_MASK_WR: begin
			nmi_mask_q = (it.write_data & (inmc_pkg::NMI_INTRQ | inmc_pkg::NMI_MOTOROFF)) |
			             inmc_pkg::NMI_RESET;
			refresh_nmi();
		end
		inmc_pkg::CMD_NMI_TAKEN: begin
			if (nmi_line_q)
				nmi_seen_q = 1'b1;
		end
		default: ;
		endcase
		r.irq_out = irq_line_q;
		r.nmi_out = nmi_line_q;
		r.nmi_seen_out = nmi_seen_q;
		r.cassette_enables = irq_mask_q[1:0];
		return r;
	endfunction

	// sender and receiver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_fire)) begin
			if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				inmc_pkg::item_t it;
				it = cmd_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= it.command;
				s_tdata  <= {7'b0, it.write_data, it.level};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= arst_n && ($urandom_range(99) >= rx_stall_pct);
	end

	// predict on accepted commands, check status transfers
	always @(posedge clk) begin
		s_fire <= s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				inmc_pkg::item_t it;
				it.command = s_tuser;
				it.level = s_tdata[0];
				it.write_data = s_tdata[8:1];
				status_due.push_back(predict_status(it));
				cmds_accepted++;
			end
			if (m_tvalid && m_tready) begin
				inmc_pkg::result_t got, want;
				got = inmc_pkg::result_t'(m_tdata[12:0]);
				if (status_due.size() == 0) begin
					$error("status transfer with nothing outstanding: %h", m_tdata);
					errors++;
				end else begin
					want = status_due.pop_front();
					status_checked++;
					if (got.read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h", want.read_data, got.read_data);
						errors++;
					end
					if (got.irq_out !== want.irq_out) begin
						$error("irq_out: expected %b, got %b", want.irq_out, got.irq_out);
						errors++;
					end
					if (got.nmi_out !== want.nmi_out) begin
						$error("nmi_out: expected %b, got %b", want.nmi_out, got.nmi_out);
						errors++;
					end
					if (got.nmi_seen_out !== want.nmi_seen_out) begin
						$error("nmi_seen_out: expected %b, got %b",
							want.nmi_seen_out, got.nmi_seen_out);
						errors++;
					end
					if (got.cassette_enables !== want.cassette_enables) begin
						$error("cassette_enables: expected %b, got %b",
							want.cassette_enables, got.cassette_enables);
						errors++;
					end
				end
			end
		end
	end

	task automatic queue_cmd(logic [3:0] c, logic l, logic [7:0] w);
		inmc_pkg::item_t it;
		it.command = c;
		it.level = l;
		it.write_data = w;
		cmd_backlog.push_back(it);
	endtask

	task automatic queue_random(int n);
		logic [7:0] w;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(7))
			0: w = 8'h00;
			1: w = 8'hFF;
			default: w = 8'($urandom_range(255));
			endcase
			queue_cmd(4'($urandom_range(15)), 1'($urandom_range(1)), w);
		end
	endtask

	task automatic drain();
		while (cmd_backlog.size() != 0 || s_tvalid || status_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_model(logic [2:0] m);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		model_q = m;
		models_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(int mode);
		case (mode)
		0: begin send_gap_pct = 0;  rx_stall_pct = 0;  end
		1: begin send_gap_pct = 63; rx_stall_pct = 0;  end
		2: begin send_gap_pct = 0;  rx_stall_pct = 63; end
		default: begin send_gap_pct = 35; rx_stall_pct = 35; end
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		s_fire = 1'b0;
		errors = 0;
		cmds_accepted = 0;
		status_checked = 0;
		models_used = 0;
		set_idling(0);
		model_q = inmc_pkg::MODEL_EARLY;
		irq_latch_q = '0;
		irq_mask_q = '0;
		nmi_latch_q = inmc_pkg::NMI_CONSTANT;
		nmi_mask_q = inmc_pkg::NMI_RESET;
		irq_line_q = 1'b0;
		nmi_line_q = 1'b0;
		nmi_seen_q = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// early layout walk
		write_model(inmc_pkg::MODEL_EARLY);
		queue_cmd(inmc_pkg::CMD_IRQ_MASK_WR, 1'b0, 8'hFF);
		queue_cmd(inmc_pkg::CMD_CAS_RISE, 1'b0, 8'h00);
		queue_cmd(inmc_pkg::CMD_CAS_FALL, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_CAS_CLEAR, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_TIMER, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_DISK, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_IRQ_READ, 1'b0, 8'h00);
		queue_cmd(inmc_pkg::CMD_DISK, 1'b0, 8'h00);
		queue_cmd(inmc_pkg::CMD_MOTOR_OFF, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_UART_RCV, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_RESET_BUTTON, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_NMI_TAKEN, 1'b0, 8'h00);
		queue_cmd(inmc_pkg::CMD_NMI_READ, 1'b0, 8'h00);
		queue_cmd(inmc_pkg::CMD_RESET_BUTTON, 1'b0, 8'h00);
		queue_cmd(CMD_UNUSED, 1'b1, 8'hFF);
		drain();

		// later layout walk
		write_model(3'd4);
		queue_cmd(inmc_pkg::CMD_NMI_MASK_WR, 1'b0, 8'hFF);
		queue_cmd(inmc_pkg::CMD_NMI_TAKEN, 1'b0, 8'h00);
		queue_cmd(inmc_pkg::CMD_DISK, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_NMI_TAKEN, 1'b0, 8'h00);
		queue_cmd(inmc_pkg::CMD_MOTOR_OFF, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_RESET_BUTTON, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_NMI_READ, 1'b0, 8'h00);
		queue_cmd(inmc_pkg::CMD_DISK, 1'b0, 8'h00);
		queue_cmd(inmc_pkg::CMD_MOTOR_OFF, 1'b0, 8'h00);
		queue_cmd(inmc_pkg::CMD_RESET_BUTTON, 1'b0, 8'h00);
		queue_cmd(inmc_pkg::CMD_UART_ERR, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_UART_SND, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_TIMER, 1'b1, 8'h00);
		queue_cmd(inmc_pkg::CMD_IRQ_MASK_WR, 1'b0, 8'h55);
		queue_cmd(inmc_pkg::CMD_IRQ_READ, 1'b0, 8'h00);
		queue_cmd(inmc_pkg::CMD_NMI_MASK_WR, 1'b1, 8'h00);
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			write_model(3'(phase_model[p]));
			set_idling(p % 4);
			queue_random(PHASE_ITEMS / 2);
			// hold off the sender until every status transfer is back
			drain();
			queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
			drain();
		end

		repeat (4) @(posedge clk);
		$display("Checked %0d status transfers for %0d commands over %0d model writes,",
			status_checked, cmds_accepted, models_used);
		$display("covering early and later layouts under four idling mixes.");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/inmc_pkg.sv
design/inmc_core.sv
design/irq_nmi_latch_mask_controller.sv
design/inmc_checker.sv
dv/tb_top.sv
